// File: src/rolt_pkg.sv
// Package for the resource ownership lock table.
// Holds the request and result types, the command and status codes and the default sizes.
// It depends on nothing else.
`default_nettype none

package rolt_pkg;

  localparam int TABLE_ENTRIES_DEF = 512;
  localparam int KEY_BITS_DEF      = 16;
  localparam int IN_KEY_W          = 16;

  localparam logic [2:0] CMD_ACQUIRE = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_LOCK    = 3'd2;
  localparam logic [2:0] CMD_UNLOCK  = 3'd3;
  localparam logic [2:0] CMD_CLEANUP = 3'd4;

  localparam logic [1:0] STAT_ACK       = 2'd0;
  localparam logic [1:0] STAT_INVALID   = 2'd1;
  localparam logic [1:0] STAT_NOT_AVAIL = 2'd2;
  localparam logic [1:0] STAT_NOT_HELD  = 2'd3;

  localparam logic [7:0] MODE_MIN = 8'h01;
  localparam logic [7:0] MODE_MAX = 8'h03;

  typedef struct packed {
    logic [2:0]          command;
    logic [IN_KEY_W-1:0] resource_key;
    logic [31:0]         requester_session;
    logic [7:0]          disconnect_mode;
    logic                resource_defined;
  } rolt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        revoke_valid;
    logic [31:0] revoked_session;
  } rolt_out_t;

  typedef struct packed {
    logic [31:0] owner;
    logic        locked;
    logic [1:0]  mode;
  } rolt_rec_t;

endpackage

`default_nettype wire

// File: src/resource_ownership_lock_table_core.sv
// Top level of the resource ownership lock table: command sequencer, search and cleanup walk.
// Depends on rolt_pkg and rolt_table.
//
// One request is taken when start is high and busy is low; its single result appears on
// out_result for one cycle with out_valid high and cannot be held off, so it must be taken
// when shown. Requests are handled one at a time by a sequential walk over the allocated
// entries, one entry read per cycle from a table memory with one read and one write port.
// A rejected request (bad command, or on acquire a bad mode or undefined resource) answers in
// the cycle after it is taken. Acquire, release, lock and unlock stop at the first matching key;
// session cleanup always walks every allocated entry. The table needs no clearing after reset,
// since only allocated entries are ever read.
`default_nettype none

module resource_ownership_lock_table_core
  import rolt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output      logic      busy,
  input  wire rolt_in_t  in_request,
  output      logic      out_valid,
  output      rolt_out_t out_result
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  rolt_out_t           out_result_r, out_result_nxt;
  logic [2:0]          cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [31:0]         sess_r, sess_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic                hit_r, hit_nxt;
  logic [IW-1:0]       hit_idx_r, hit_idx_nxt;
  rolt_rec_t           hit_rec_r, hit_rec_nxt;

  logic [KEY_BITS-1:0] in_key;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  rolt_rec_t           rd_rec;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  rolt_rec_t           wr_rec;
  logic                key_hit;
  logic                own_hit;
  logic                lookup;
  logic                bad_request;

  generate
    if (KEY_BITS > IN_KEY_W) begin : g_key_wide
      assign in_key = {{(KEY_BITS - IN_KEY_W){1'b0}}, in_request.resource_key};
    end else if (KEY_BITS == IN_KEY_W) begin : g_key_same
      assign in_key = in_request.resource_key;
    end else begin : g_key_narrow
      assign in_key = in_request.resource_key[KEY_BITS-1:0];
    end
  endgenerate

  rolt_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_rec  (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_rec  (wr_rec)
  );

  assign key_hit     = rd_vld_r && (rd_key == key_r);
  assign own_hit     = rd_vld_r && (rd_rec.owner == sess_r);
  assign lookup      = (cmd_r != CMD_CLEANUP);
  assign bad_request = (in_request.command > CMD_CLEANUP) ||
                       ((in_request.command == CMD_ACQUIRE) &&
                        ((in_request.disconnect_mode < MODE_MIN) ||
                         (in_request.disconnect_mode > MODE_MAX) ||
                         !in_request.resource_defined));

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = idx_r[IW-1:0];
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    sess_nxt       = sess_r;
    mode_nxt       = mode_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rec_nxt    = hit_rec_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r[IW-1:0];
    wr_en          = 1'b0;
    wr_addr        = rd_idx_r;
    wr_key         = rd_key;
    wr_rec         = rd_rec;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_request.command;
          key_nxt  = in_key;
          sess_nxt = in_request.requester_session;
          mode_nxt = in_request.disconnect_mode[1:0];
          hit_nxt  = 1'b0;
          idx_nxt  = '0;
          if (bad_request) begin
            out_valid_nxt                  = 1'b1;
            out_result_nxt.status          = STAT_INVALID;
            out_result_nxt.revoke_valid    = 1'b0;
            out_result_nxt.revoked_session = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (lookup && key_hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = rd_idx_r;
          hit_rec_nxt = rd_rec;
          state_nxt   = S_EXEC;
        end else if ((idx_r == used_r) && !rd_vld_r) begin
          if (lookup) begin
            state_nxt = S_EXEC;
          end else begin
            out_valid_nxt                  = 1'b1;
            out_result_nxt.status          = STAT_ACK;
            out_result_nxt.revoke_valid    = 1'b0;
            out_result_nxt.revoked_session = '0;
            state_nxt                      = S_IDLE;
          end
        end else begin
          if (idx_r != used_r) begin
            rd_en      = 1'b1;
            idx_nxt    = idx_r + CW'(1);
            rd_vld_nxt = 1'b1;
          end
          if (!lookup && own_hit) begin
            wr_en         = 1'b1;
            wr_rec.owner  = '0;
            wr_rec.locked = 1'b0;
          end
        end
      end

      S_EXEC: begin
        state_nxt                      = S_IDLE;
        out_valid_nxt                  = 1'b1;
        out_result_nxt.status          = STAT_ACK;
        out_result_nxt.revoke_valid    = 1'b0;
        out_result_nxt.revoked_session = '0;
        wr_addr                        = hit_idx_r;
        wr_key                         = key_r;
        wr_rec                         = hit_rec_r;
        if (cmd_r == CMD_ACQUIRE) begin
          if (hit_r && (hit_rec_r.owner != '0)) begin
            if (hit_rec_r.owner == sess_r) begin
              wr_en       = 1'b1;
              wr_rec.mode = mode_r;
            end else if (hit_rec_r.locked) begin
              out_result_nxt.status = STAT_NOT_AVAIL;
            end else begin
              wr_en                          = 1'b1;
              wr_rec.owner                   = sess_r;
              wr_rec.locked                  = 1'b0;
              wr_rec.mode                    = mode_r;
              out_result_nxt.revoke_valid    = 1'b1;
              out_result_nxt.revoked_session = hit_rec_r.owner;
            end
          end else if (!hit_r && (used_r == CW'(TABLE_ENTRIES))) begin
            out_result_nxt.status = STAT_NOT_AVAIL;
          end else begin
            wr_en         = 1'b1;
            wr_rec.owner  = sess_r;
            wr_rec.locked = 1'b0;
            wr_rec.mode   = mode_r;
            if (!hit_r) begin
              wr_addr  = used_r[IW-1:0];
              used_nxt = used_r + CW'(1);
            end
          end
        end else if (!hit_r || (hit_rec_r.owner != sess_r)) begin
          out_result_nxt.status = STAT_NOT_HELD;
        end else begin
          wr_en = 1'b1;
          if (cmd_r == CMD_RELEASE) begin
            wr_rec.owner  = '0;
            wr_rec.locked = 1'b0;
          end else if (cmd_r == CMD_LOCK) begin
            wr_rec.locked = 1'b1;
          end else begin
            wr_rec.locked = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_result_r <= out_result_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    sess_r       <= sess_nxt;
    mode_r       <= mode_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_rec_r    <= hit_rec_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

// File: src/rolt_table.sv
// Entry store of the resource ownership lock table: one key and one record per entry.
// One write port and one registered read port. Depends on rolt_pkg.
`default_nettype none

module rolt_table
  import rolt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  localparam int IW           = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire logic [IW-1:0]       rd_addr,
  output      logic [KEY_BITS-1:0] rd_key,
  output      rolt_rec_t           rd_rec,
  input  wire logic                wr_en,
  input  wire logic [IW-1:0]       wr_addr,
  input  wire logic [KEY_BITS-1:0] wr_key,
  input  wire rolt_rec_t           wr_rec
);

  localparam int REC_W  = $bits(rolt_rec_t);
  localparam int WORD_W = KEY_BITS + REC_W;

  logic [WORD_W-1:0] mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_rec};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign rd_key = rd_word_r[WORD_W-1:REC_W];
  assign rd_rec = rolt_rec_t'(rd_word_r[REC_W-1:0]);

endmodule

`default_nettype wire

// File: tb/resource_ownership_lock_table_core_tb.sv
// Testbench for the resource ownership lock table core: directed, random and full-table traffic,
// every result checked against a behavioural model of the table kept in this file.
// Depends on rolt_pkg and resource_ownership_lock_table_core.
`timescale 1ns / 1ps

module resource_ownership_lock_table_core_tb;
  import rolt_pkg::*;

  localparam int TBL_DEPTH = TABLE_ENTRIES_DEF;
  localparam int MAX_GAP = 30;
  localparam int WATCHDOG_LIMIT = 4 * (TBL_DEPTH + MAX_GAP + 8);
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  rolt_in_t in_request = '0;
  logic busy;
  logic out_valid;
  rolt_out_t out_result;

  logic [IN_KEY_W-1:0] held_key [TBL_DEPTH];
  logic [31:0] held_owner [TBL_DEPTH];
  logic held_locked [TBL_DEPTH];
  logic [1:0] held_mode [TBL_DEPTH];
  int held_count = 0;

  rolt_out_t pending_results [$];
  logic [IN_KEY_W-1:0] key_pool [16];
  logic [31:0] session_pool [8];
  int idle_pct = 0;
  int requests_sent = 0;
  int fault_count = 0;
  int revokes_checked = 0;
  int refusals_checked = 0;

  resource_ownership_lock_table_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_request (in_request),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always #2 clk = ~clk;

  function automatic int find_slot(input logic [IN_KEY_W-1:0] key);
    for (int i = 0; i < held_count; i++) begin
      if (held_key[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic rolt_out_t predict_outcome(input rolt_in_t req);
    rolt_out_t res;
    int slot;
    res = '0;
    res.status = STAT_ACK;
    slot = find_slot(req.resource_key);
    case (req.command)
      CMD_ACQUIRE: begin
        if (req.disconnect_mode < MODE_MIN || req.disconnect_mode > MODE_MAX ||
            !req.resource_defined) begin
          res.status = STAT_INVALID;
        end else if (slot >= 0 && held_owner[slot] != '0) begin
          if (held_owner[slot] == req.requester_session) begin
            held_mode[slot] = req.disconnect_mode[1:0];
          end else if (held_locked[slot]) begin
            res.status = STAT_NOT_AVAIL;
          end else begin
            res.revoke_valid = 1'b1;
            res.revoked_session = held_owner[slot];
            held_owner[slot] = req.requester_session;
            held_locked[slot] = 1'b0;
            held_mode[slot] = req.disconnect_mode[1:0];
          end
        end else if (slot < 0 && held_count >= TBL_DEPTH) begin
          res.status = STAT_NOT_AVAIL;
        end else begin
          if (slot < 0) begin
            slot = held_count;
            held_count++;
          end
          held_key[slot] = req.resource_key;
          held_owner[slot] = req.requester_session;
          held_locked[slot] = 1'b0;
          held_mode[slot] = req.disconnect_mode[1:0];
        end
      end
      CMD_RELEASE, CMD_LOCK, CMD_UNLOCK: begin
        if (slot < 0 || held_owner[slot] != req.requester_session) begin
          res.status = STAT_NOT_HELD;
        end else begin
          if (req.command == CMD_RELEASE) begin
            held_owner[slot] = '0;
          end
          held_locked[slot] = (req.command == CMD_LOCK);
        end
      end
      CMD_CLEANUP: begin
        for (int i = 0; i < held_count; i++) begin
          if (held_owner[i] == req.requester_session) begin
            held_owner[i] = '0;
            held_locked[i] = 1'b0;
          end
        end
      end
      default: begin
        res.status = STAT_INVALID;
      end
    endcase
    return res;
  endfunction

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic [IN_KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 85) begin
      return key_pool[$urandom_range(15)];
    end
    return IN_KEY_W'($urandom);
  endfunction

  function automatic logic [31:0] pick_session();
    if ($urandom_range(99) < 85) begin
      return session_pool[$urandom_range(7)];
    end
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_mode();
    return 8'($urandom_range(MODE_MAX, MODE_MIN));
  endfunction

  task automatic issue(input logic [2:0] cmd, input logic [IN_KEY_W-1:0] key,
                       input logic [31:0] sess, input logic [7:0] mode, input logic defd);
    rolt_in_t req;
    int gap;
    req.command = cmd;
    req.resource_key = key;
    req.requester_session = sess;
    req.disconnect_mode = mode;
    req.resource_defined = defd;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_request <= req;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_results.push_back(predict_outcome(req));
    requests_sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    logic [31:0] sa;
    logic [31:0] sb;
    sa = 32'h0000_1001;
    sb = 32'hFFFF_FFFF;
    issue(CMD_ACQUIRE, '0, sa, MODE_MIN, 1'b1);
    issue(CMD_ACQUIRE, '0, sa, MODE_MAX, 1'b1);
    issue(CMD_ACQUIRE, '0, sa, MODE_MIN - 8'd1, 1'b1);
    issue(CMD_ACQUIRE, '0, sa, MODE_MAX + 8'd1, 1'b1);
    issue(CMD_ACQUIRE, '1, sa, 8'hFF, 1'b1);
    issue(CMD_ACQUIRE, '1, sb, 8'd2, 1'b0);
    issue(CMD_ACQUIRE, '1, sb, 8'd2, 1'b1);
    issue(CMD_LOCK, '0, sb, 8'h00, 1'b1);
    issue(CMD_LOCK, '0, sa, 8'h00, 1'b1);
    issue(CMD_ACQUIRE, '0, sb, 8'd2, 1'b1);
    issue(CMD_UNLOCK, '0, sa, 8'h00, 1'b1);
    issue(CMD_ACQUIRE, '0, sb, 8'd2, 1'b1);
    issue(CMD_RELEASE, '0, sa, 8'h00, 1'b1);
    issue(CMD_RELEASE, '0, sb, 8'h00, 1'b1);
    issue(CMD_RELEASE, '0, '0, 8'h00, 1'b1);
    issue(CMD_LOCK, '0, '0, 8'h00, 1'b1);
    issue(CMD_ACQUIRE, '0, sa, MODE_MIN, 1'b1);
    issue(CMD_RELEASE, 16'h5A5A, sa, 8'h00, 1'b1);
    issue(CMD_UNLOCK, 16'h5A5A, sa, 8'h00, 1'b1);
    issue(CMD_LOCK, 16'h5A5A, '0, 8'h00, 1'b1);
    issue(CMD_CLEANUP, '0, sa, 8'h00, 1'b1);
    issue(CMD_CLEANUP, '0, sb, 8'h00, 1'b1);
    issue(CMD_CLEANUP, '0, '0, 8'h00, 1'b1);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
      issue(c[2:0], '1, sa, MODE_MIN, 1'b1);
    end
  endtask

  task automatic test_random_traffic(input int count);
    int goal;
    logic [IN_KEY_W-1:0] key;
    logic [31:0] holder;
    logic [31:0] rival;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      if ($urandom_range(99) < 70) begin
        key = pick_key();
        holder = pick_session();
        rival = pick_session();
        issue(CMD_ACQUIRE, key, holder, pick_mode(), 1'b1);
        repeat ($urandom_range(6, 2)) begin
          case ($urandom_range(5))
            0: begin
              issue(CMD_LOCK, key, holder, 8'($urandom), 1'b1);
            end
            1: begin
              issue(CMD_UNLOCK, key, holder, 8'($urandom), 1'b1);
            end
            2: begin
              issue(CMD_ACQUIRE, key, rival, pick_mode(), 1'b1);
            end
            3: begin
              issue(CMD_ACQUIRE, key, holder, pick_mode(), 1'b1);
            end
            4: begin
              issue(CMD_RELEASE, key, $urandom_range(1) ? holder : rival, 8'($urandom), 1'b1);
            end
            default: begin
              issue(CMD_CLEANUP, IN_KEY_W'($urandom), $urandom_range(3) == 0 ? rival : holder,
                    8'($urandom), 1'b1);
            end
          endcase
        end
      end else begin
        issue(3'($urandom_range(7)), pick_key(), pick_session(), 8'($urandom_range(255)),
              $urandom_range(3) != 0);
      end
    end
  endtask

  task automatic test_table_exhaustion();
    logic [IN_KEY_W-1:0] key;
    int refused;
    while (held_count < TBL_DEPTH) begin
      key = IN_KEY_W'($urandom);
      if (find_slot(key) < 0) begin
        issue(CMD_ACQUIRE, key, pick_session(), pick_mode(), 1'b1);
      end
    end
    refused = 0;
    while (refused < 12) begin
      key = IN_KEY_W'($urandom);
      if (find_slot(key) < 0) begin
        issue(CMD_ACQUIRE, key, pick_session(), pick_mode(), 1'b1);
        refused++;
      end
    end
  endtask

  always @(negedge clk) begin
    rolt_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        log_fault($sformatf("Unrequested result: status %0d revoke %0b session %h",
                            out_result.status, out_result.revoke_valid,
                            out_result.revoked_session));
      end else begin
        want = pending_results.pop_front();
        if (out_result.status !== want.status ||
            out_result.revoke_valid !== want.revoke_valid ||
            out_result.revoked_session !== want.revoked_session) begin
          log_fault($sformatf({"Result mismatch: expected status %0d revoke %0b session %h, ",
                               "got status %0d revoke %0b session %h"},
                              want.status, want.revoke_valid, want.revoked_session,
                              out_result.status, out_result.revoke_valid,
                              out_result.revoked_session));
        end
        if (want.revoke_valid) begin
          revokes_checked++;
        end
        if (want.status == STAT_NOT_AVAIL) begin
          refusals_checked++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((start && !busy) || out_valid) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL resource_ownership_lock_table_core");
    $finish;
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) begin
      key_pool[i] = IN_KEY_W'($urandom);
    end
    session_pool[0] = '0;
    session_pool[1] = '1;
    for (int i = 2; i < 8; i++) begin
      session_pool[i] = $urandom;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 21;
    test_directed();
    test_random_traffic(250);
    hold_until_drained();
    idle_pct = 51;
    test_random_traffic(200);
    hold_until_drained();
    idle_pct = 0;
    test_table_exhaustion();
    test_random_traffic(200);
    hold_until_drained();
    repeat (TBL_DEPTH + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      log_fault($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("Checked %0d requests at three pacing levels, %0d of them revoking an owner.",
             requests_sent, revokes_checked);
    $display("Table filled to %0d entries; %0d acquires refused as not available.",
             held_count, refusals_checked);
    if (fault_count == 0) begin
      $display("PASS resource_ownership_lock_table_core");
    end else begin
      $display("FAIL resource_ownership_lock_table_core");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rolt_pkg.sv
src/rolt_table.sv
src/resource_ownership_lock_table_core.sv
tb/resource_ownership_lock_table_core_tb.sv
